FILE: src/stk_pkg.sv
`timescale 1ns / 1ps

package stk_pkg;

  // Default depth of the queue between the scanner and the output stage.
  localparam int unsigned QueueDepthDefault = 4;

  // Token kinds.
  localparam logic [3:0] KIND_ID     = 4'd0;
  localparam logic [3:0] KIND_INT    = 4'd1;
  localparam logic [3:0] KIND_STR    = 4'd2;
  localparam logic [3:0] KIND_EQUALS = 4'd3;
  localparam logic [3:0] KIND_LPAREN = 4'd4;
  localparam logic [3:0] KIND_RPAREN = 4'd5;
  localparam logic [3:0] KIND_LBRACE = 4'd6;
  localparam logic [3:0] KIND_RBRACE = 4'd7;
  localparam logic [3:0] KIND_COMMA  = 4'd8;
  localparam logic [3:0] KIND_LT     = 4'd9;
  localparam logic [3:0] KIND_GT     = 4'd10;
  localparam logic [3:0] KIND_SEMI   = 4'd11;
  localparam logic [3:0] KIND_PLUS   = 4'd12;
  localparam logic [3:0] KIND_EOF    = 4'd13;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
  localparam logic [2:0] ERR_UNTERM_STR   = 3'd2;
  localparam logic [2:0] ERR_UNTERM_CMT   = 3'd3;
  localparam logic [2:0] ERR_LONE_SLASH   = 3'd4;

  // One result word.
  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] char_out;
    logic       char_valid;
    logic       token_end;
    logic [2:0] error_code;
  } item_t;

  // The words caused by one source byte: one, or two when an identifier or integer closes.
  typedef struct packed {
    logic  two;
    item_t first;
    item_t second;
  } entry_t;

  // Queue head as seen by the output stage.
  typedef struct packed {
    logic   not_empty;
    entry_t head;
  } q_status_t;

  function automatic item_t mk_item(logic [3:0] kind, logic [7:0] ch, logic valid,
                                    logic last, logic [2:0] err);
    item_t it;
    it.token_kind = kind;
    it.char_out   = ch;
    it.char_valid = valid;
    it.token_end  = last;
    it.error_code = err;
    return it;
  endfunction

endpackage

FILE: src/stk_front.sv
`timescale 1ns / 1ps

module stk_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      ch_i,
  output logic            push_o,
  output stk_pkg::entry_t entry_o
);

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_ID    = 4'd1,
    MODE_INT   = 4'd2,
    MODE_STR   = 4'd3,
    MODE_ESC   = 4'd4,
    MODE_SLASH = 4'd5,
    MODE_CMT   = 4'd6,
    MODE_CSTAR = 4'd7,
    MODE_HALT  = 4'd8
  } mode_e;

  typedef struct packed {
    logic           emit;
    stk_pkg::item_t item;
    mode_e          mode;
  } idle_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_BS    = 8'h08;

  mode_e mode_q, mode_d;
  logic  has_first, has_second;
  stk_pkg::item_t first, second;
  idle_t idle;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Returns the punctuator kind, or KIND_ID when the byte is not one.
  function automatic logic [3:0] punct_kind(logic [7:0] c);
    logic [3:0] k;
    case (c)
      "=":     k = stk_pkg::KIND_EQUALS;
      "(":     k = stk_pkg::KIND_LPAREN;
      ")":     k = stk_pkg::KIND_RPAREN;
      "{":     k = stk_pkg::KIND_LBRACE;
      "}":     k = stk_pkg::KIND_RBRACE;
      ",":     k = stk_pkg::KIND_COMMA;
      "<":     k = stk_pkg::KIND_LT;
      ">":     k = stk_pkg::KIND_GT;
      ";":     k = stk_pkg::KIND_SEMI;
      "+":     k = stk_pkg::KIND_PLUS;
      default: k = stk_pkg::KIND_ID;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    logic [7:0] r;
    case (c)
      "n":     r = CH_LF;
      "t":     r = CH_TAB;
      "r":     r = CH_CR;
      "f":     r = CH_FF;
      "b":     r = CH_BS;
      default: r = c;
    endcase
    return r;
  endfunction

  // Scan of a byte between tokens.
  function automatic idle_t scan_idle(logic [7:0] c);
    idle_t      r;
    logic [3:0] k;
    k      = punct_kind(c);
    r.emit = 1'b0;
    r.item = '0;
    r.mode = MODE_IDLE;
    if (c == CH_NUL) begin
      r.emit = 1'b1;
      r.item = stk_pkg::mk_item(stk_pkg::KIND_EOF, CH_NUL, 1'b0, 1'b1, stk_pkg::ERR_NONE);
    end else if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR) begin
      r.mode = MODE_IDLE;
    end else if (is_letter(c)) begin
      r.emit = 1'b1;
      r.item = stk_pkg::mk_item(stk_pkg::KIND_ID, c, 1'b1, 1'b0, stk_pkg::ERR_NONE);
      r.mode = MODE_ID;
    end else if (is_digit(c)) begin
      r.emit = 1'b1;
      r.item = stk_pkg::mk_item(stk_pkg::KIND_INT, c, 1'b1, 1'b0, stk_pkg::ERR_NONE);
      r.mode = MODE_INT;
    end else if (c == CH_QUOTE) begin
      r.mode = MODE_STR;
    end else if (c == CH_SLASH) begin
      r.mode = MODE_SLASH;
    end else if (k != stk_pkg::KIND_ID) begin
      r.emit = 1'b1;
      r.item = stk_pkg::mk_item(k, c, 1'b1, 1'b1, stk_pkg::ERR_NONE);
    end else begin
      r.emit = 1'b1;
      r.item = stk_pkg::mk_item(stk_pkg::KIND_ID, c, 1'b0, 1'b0, stk_pkg::ERR_UNEXPECTED);
      r.mode = MODE_HALT;
    end
    return r;
  endfunction

  always_comb begin
    idle       = scan_idle(ch_i);
    mode_d     = mode_q;
    has_first  = 1'b0;
    has_second = 1'b0;
    first      = '0;
    second     = idle.item;
    case (mode_q)
      MODE_ID, MODE_INT: begin
        if ((mode_q == MODE_ID) ? is_letter(ch_i) : is_digit(ch_i)) begin
          has_first = 1'b1;
          first = stk_pkg::mk_item((mode_q == MODE_ID) ? stk_pkg::KIND_ID : stk_pkg::KIND_INT,
                                   ch_i, 1'b1, 1'b0, stk_pkg::ERR_NONE);
        end else begin
          // The byte closes the token and is then scanned as a fresh start.
          has_first  = 1'b1;
          first = stk_pkg::mk_item((mode_q == MODE_ID) ? stk_pkg::KIND_ID : stk_pkg::KIND_INT,
                                   CH_NUL, 1'b0, 1'b1, stk_pkg::ERR_NONE);
          has_second = idle.emit;
          mode_d     = idle.mode;
        end
      end
      MODE_STR: begin
        if (ch_i == CH_NUL) begin
          has_first = 1'b1;
          first = stk_pkg::mk_item(stk_pkg::KIND_ID, CH_NUL, 1'b0, 1'b0,
                                   stk_pkg::ERR_UNTERM_STR);
          mode_d = MODE_IDLE;
        end else if (ch_i == CH_QUOTE) begin
          has_first = 1'b1;
          first = stk_pkg::mk_item(stk_pkg::KIND_STR, CH_NUL, 1'b0, 1'b1, stk_pkg::ERR_NONE);
          mode_d = MODE_IDLE;
        end else if (ch_i == CH_BSL) begin
          mode_d = MODE_ESC;
        end else begin
          has_first = 1'b1;
          first = stk_pkg::mk_item(stk_pkg::KIND_STR, ch_i, 1'b1, 1'b0, stk_pkg::ERR_NONE);
        end
      end
      MODE_ESC: begin
        has_first = 1'b1;
        if (ch_i == CH_NUL) begin
          first = stk_pkg::mk_item(stk_pkg::KIND_ID, CH_NUL, 1'b0, 1'b0,
                                   stk_pkg::ERR_UNTERM_STR);
          mode_d = MODE_IDLE;
        end else begin
          first = stk_pkg::mk_item(stk_pkg::KIND_STR, unescape(ch_i), 1'b1, 1'b0,
                                   stk_pkg::ERR_NONE);
          mode_d = MODE_STR;
        end
      end
      MODE_SLASH: begin
        if (ch_i == CH_STAR) begin
          mode_d = MODE_CMT;
        end else begin
          has_first = 1'b1;
          first = stk_pkg::mk_item(stk_pkg::KIND_ID, CH_NUL, 1'b0, 1'b0,
                                   stk_pkg::ERR_LONE_SLASH);
          mode_d = (ch_i == CH_NUL) ? MODE_IDLE : MODE_HALT;
        end
      end
      MODE_CMT, MODE_CSTAR: begin
        if (ch_i == CH_NUL) begin
          has_first = 1'b1;
          first = stk_pkg::mk_item(stk_pkg::KIND_ID, CH_NUL, 1'b0, 1'b0,
                                   stk_pkg::ERR_UNTERM_CMT);
          mode_d = MODE_IDLE;
        end else if (ch_i == CH_STAR) begin
          mode_d = MODE_CSTAR;
        end else if (mode_q == MODE_CSTAR && ch_i == CH_SLASH) begin
          mode_d = MODE_IDLE;
        end else begin
          mode_d = MODE_CMT;
        end
      end
      MODE_HALT: begin
        if (ch_i == CH_NUL) begin
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        has_first = idle.emit;
        first     = idle.item;
        mode_d    = idle.mode;
      end
    endcase
  end

  assign push_o        = accept_i && has_first;
  assign entry_o.two    = has_first && has_second;
  assign entry_o.first  = first;
  assign entry_o.second = second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

  // Halted scanning swallows every byte.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == MODE_HALT) |-> !push_o)
    else $error("halted scanner produced a word");

  // Only the close of an identifier or integer can produce a second word.
  a_two_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.two) |-> ((mode_q == MODE_ID || mode_q == MODE_INT)
                                 && entry_o.first.token_end))
    else $error("second word outside a token close");

endmodule

FILE: src/stk_queue.sv
`timescale 1ns / 1ps

module stk_queue #(
  parameter int unsigned Depth = stk_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  stk_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output logic               full_o,
  output stk_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  stk_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o             = (count_q == CntW'(Depth));
  assign status_o.not_empty = (count_q != '0);
  assign status_o.head      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.not_empty)
    else $error("pop from an empty queue");

endmodule

FILE: src/stk_back.sv
`timescale 1ns / 1ps

module stk_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stk_pkg::q_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stk_pkg::item_t     item_o
);

  logic           out_valid_q;
  stk_pkg::item_t out_q;
  logic           sec_valid_q;
  stk_pkg::item_t sec_q;
  logic           slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  // A held second word goes out before the queue is read again.
  assign pop_o       = slot_free && !sec_valid_q && status_i.not_empty;
  assign out_valid_o = out_valid_q;
  assign item_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (slot_free) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= status_i.not_empty;
        sec_valid_q <= status_i.not_empty && status_i.head.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (sec_valid_q) begin
        out_q <= sec_q;
      end else begin
        out_q <= status_i.head.first;
        sec_q <= status_i.head.second;
      end
    end
  end

  a_second_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_valid_q |-> out_valid_q)
    else $error("held second word without a word in the output register");

endmodule

FILE: src/source_tokenizer_unit.sv
`timescale 1ns / 1ps

// Streaming source tokenizer.
// The input channel carries one source byte per word on ch_i; byte 0 ends the text.
// A word is accepted on a rising edge where in_valid_i is high and in_stall_o is low.
// The output channel carries one result word per transfer: token kind, character,
// character-valid flag, token-end flag and error code, taken on a rising edge where
// out_valid_o is high and out_stall_i is low.
// An accepted byte's first result word is written into the queue and then into the
// output register before it shows on the outputs.
// Throughput: one byte per cycle in while in_stall_o is low and one result word per
// cycle out while out_stall_i is low. A byte that closes an identifier or integer and
// also starts something that yields a word gives two words, so the output side needs
// two transfers for it; the queue between the scanner and output stage absorbs that.
// The scanner state machine updates once per accepted byte; the queue depth sets how
// long the output side may stall before in_stall_o rises.
// Reset clears the scanner to the between-tokens state and empties the queue and the
// output register. When the receiver stalls, the current word holds steady, the
// queue fills, and then the input side stalls too. After an unexpected byte or a lone
// slash not followed by byte 0, the scanner swallows bytes until byte 0 resets it to idle.
module source_tokenizer_unit #(
  parameter int unsigned QueueDepth = stk_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       token_end_o,
  output logic [2:0] error_code_o
);

  logic               accept;
  logic               push;
  logic               pop;
  logic               full;
  stk_pkg::entry_t    entry;
  stk_pkg::q_status_t status;
  stk_pkg::item_t     item;

  // The scanner stalls only when the queue has no room for what a byte may yield.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  stk_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  stk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .full_o   (full),
    .status_o (status)
  );

  stk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (item)
  );

  assign token_kind_o = item.token_kind;
  assign char_out_o   = item.char_out;
  assign char_valid_o = item.char_valid;
  assign token_end_o  = item.token_end;
  assign error_code_o = item.error_code;

endmodule
